[design/pwt_pkg.sv]
// Shared types and constants of the prefetch window tracker.
package pwt_pkg;

    // Ring geometry.
    localparam int RING_DEPTH = 64;
    localparam int POS_W      = $clog2(RING_DEPTH);
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);

    // Field widths.
    localparam int IDX_W      = 32;
    localparam int WIN_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_START    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_CAP      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIDDEN_ON_START = 2'd2;

    // Request types.
    localparam logic [2:0] REQ_ISSUE   = 3'd0;
    localparam logic [2:0] REQ_REPLY   = 3'd1;
    localparam logic [2:0] REQ_CONSUME = 3'd2;
    localparam logic [2:0] REQ_ACCOUNT = 3'd3;
    localparam logic [2:0] REQ_STOP    = 3'd4;

    // Result status codes.
    localparam logic [2:0] ST_OK             = 3'd0;
    localparam logic [2:0] ST_WINDOW_FULL    = 3'd1;
    localparam logic [2:0] ST_PRODUCER_STOP  = 3'd2;
    localparam logic [2:0] ST_HIDDEN_SKIPPED = 3'd3;
    localparam logic [2:0] ST_NOT_READY      = 3'd4;
    localparam logic [2:0] ST_DRAINED        = 3'd5;
    localparam logic [2:0] ST_HIDDEN_MISSED  = 3'd6;
    localparam logic [2:0] ST_RING_FULL      = 3'd7;

    // Reply placement codes.
    localparam logic [1:0] PLACE_NONE  = 2'd0;
    localparam logic [1:0] PLACE_HEAD  = 2'd1;
    localparam logic [1:0] PLACE_LATER = 2'd2;

    // Input item.
    typedef struct packed {
        logic [2:0]       req_type;
        logic             entry_hidden;
        logic             issue_ok;
        logic             end_of_list;
        logic [IDX_W-1:0] reply_index;
        logic             was_hit;
    } in_item_t;

    // Result item.
    typedef struct packed {
        logic [2:0]       status;
        logic [IDX_W-1:0] slot_index;
        logic [1:0]       reply_place;
        logic             stop_raised;
    } out_item_t;

endpackage

[design/pwt_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module pwt_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port, and a read that returns the old contents on a collision.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[design/prefetch_window_tracker_unit.sv]
// Top level of the prefetch window tracker: event decode, tracker state and ring.
//
// Usage: events arrive on the s_ channel (s_valid, s_ready, s_item) and each one
// produces exactly one result item on the m_ channel (m_valid, m_ready, m_item).
// An event is issue, reply, consume, account or stop request; the result carries
// a status code, the index of a newly issued slot, the place of a replied slot
// and a flag that a low hit ratio has just asked the producer to stop.
// The configuration port (cfg_wr_en, cfg_wr_index, cfg_wr_data) loads the start
// window, the window cap and the hidden-entry enable; write it only while idle.
// Flow: an item accepted on the s_ channel is held in an input register and
// processed there against the state registers and the done bit of the head
// slot, which the ring RAM reads ahead at the next head; the result goes into
// the output register. Throughput: one item per cycle while m_ready is high.
// When the receiver stalls, the finished result waits in the output register
// while one more item is taken into the input register; s_ready then drops.
// Reset (aresetn low, synchronous) empties the ring, clears all counters, sets
// the run state to running and restores the register defaults. The ring RAM is
// not cleared; each slot is written when it is issued.
module prefetch_window_tracker_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  pwt_pkg::in_item_t              s_item,
    output logic                           m_valid,
    input  logic                           m_ready,
    output pwt_pkg::out_item_t             m_item,
    input  logic                           cfg_wr_en,
    input  logic [pwt_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [pwt_pkg::CFG_DATA_W-1:0] cfg_wr_data
);

    localparam int POS_W = pwt_pkg::POS_W;
    localparam int CNT_W = pwt_pkg::CNT_W;
    localparam int IDX_W = pwt_pkg::IDX_W;
    localparam int WIN_W = pwt_pkg::WIN_W;

    // Run states.
    localparam logic [1:0] RS_RUNNING  = 2'd0;
    localparam logic [1:0] RS_STOPPING = 2'd1;
    localparam logic [1:0] RS_STOPPED  = 2'd2;

    // Low hit ratio thresholds.
    localparam logic [IDX_W-1:0] HIT_FLOOR        = 32'd7;
    localparam logic [IDX_W-1:0] MISS_RUN_LIMIT   = 32'd8;
    localparam logic [IDX_W-1:0] CNT_MAX          = '1;

    // Reset values of the configurable state.
    localparam logic [WIN_W-1:0] WINDOW_START_RST = 11'd2;
    localparam logic [WIN_W-1:0] WINDOW_CAP_RST   = 11'd64;

    // Saturating counter step.
    function automatic logic [IDX_W-1:0] sat_inc(input logic [IDX_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    // Ring position of the slot after one at index idx, position pos.
    function automatic logic [POS_W-1:0] pos_inc(input logic [POS_W-1:0] pos,
                                                 input logic [IDX_W-1:0] idx);
        logic [POS_W-1:0] res;
        if (idx == CNT_MAX) begin
            res = '0;
        end else if (pos == POS_W'(pwt_pkg::RING_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = pos + 1'b1;
        end
        return res;
    endfunction

    // Handshake and pipeline registers.
    logic                in_valid_reg;
    pwt_pkg::in_item_t   in_item_reg;
    logic                m_valid_reg;
    pwt_pkg::out_item_t  m_item_reg;
    pwt_pkg::out_item_t  result;
    logic                fire;

    // Tracker state.
    logic [IDX_W-1:0] next_slot_reg, next_slot_next;
    logic [IDX_W-1:0] head_slot_reg, head_slot_next;
    logic [POS_W-1:0] next_pos_reg, next_pos_next;
    logic [POS_W-1:0] head_pos_reg, head_pos_next;
    logic [CNT_W-1:0] slot_count_reg, slot_count_next;
    logic [IDX_W-1:0] hit_count_reg, hit_count_next;
    logic [IDX_W-1:0] miss_count_reg, miss_count_next;
    logic [IDX_W-1:0] miss_run_reg, miss_run_next;
    logic [WIN_W-1:0] window_size_reg, window_size_next;
    logic [WIN_W-1:0] window_cap_reg, window_cap_next;
    logic [1:0]       run_state_reg, run_state_next;
    logic             hidden_en_reg, hidden_en_next;
    logic [IDX_W-1:0] hidden_skipped_reg, hidden_skipped_next;
    logic [IDX_W-1:0] hidden_missed_reg, hidden_missed_next;

    // Ring RAM access and head forwarding.
    logic             ram_wr_en;
    logic [POS_W-1:0] ram_wr_addr;
    logic             ram_wr_data;
    logic             ram_rd_data;
    logic             fwd_hit_reg, fwd_hit_next;
    logic             fwd_data_reg;
    logic             head_done;

    // Event helpers.
    logic [IDX_W+1:0] issue_limit;
    logic [IDX_W-1:0] reply_off;
    logic             reply_found;
    logic [POS_W:0]   reply_sum;
    logic [POS_W-1:0] reply_pos;
    logic [WIN_W:0]   window_dbl;
    logic             low_ratio;

    // The item in the input register moves on when the output register is free.
    assign fire    = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // Done bit of the current head, with the write of the last cycle forwarded.
    assign head_done = fwd_hit_reg ? fwd_data_reg : ram_rd_data;

    // Window limit and reply lookup.
    assign issue_limit = {2'b00, hit_count_reg} + {2'b00, miss_count_reg}
                       + (IDX_W + 2)'(window_size_reg);
    assign reply_off   = in_item_reg.reply_index - head_slot_reg;
    assign reply_found = reply_off < IDX_W'(slot_count_reg);
    assign reply_sum   = {1'b0, head_pos_reg} + {1'b0, reply_off[POS_W-1:0]};
    assign window_dbl  = {window_size_reg, 1'b0};

    // A slot past the index wrap sits at its own index; otherwise one reduction.
    always_comb begin
        if (in_item_reg.reply_index < head_slot_reg) begin
            reply_pos = in_item_reg.reply_index[POS_W-1:0];
        end else if (reply_sum >= (POS_W + 1)'(pwt_pkg::RING_DEPTH)) begin
            reply_pos = POS_W'(reply_sum - (POS_W + 1)'(pwt_pkg::RING_DEPTH));
        end else begin
            reply_pos = reply_sum[POS_W-1:0];
        end
    end

    // Low hit ratio test on the counts after a miss.
    assign low_ratio = (({2'b00, hit_count_reg} < {sat_inc(miss_count_reg), 2'b00})
                        && (hit_count_reg > HIT_FLOOR))
                       || (sat_inc(miss_run_reg) > MISS_RUN_LIMIT);

    // Event processing and configuration writes.
    always_comb begin
        next_slot_next      = next_slot_reg;
        head_slot_next      = head_slot_reg;
        next_pos_next       = next_pos_reg;
        head_pos_next       = head_pos_reg;
        slot_count_next     = slot_count_reg;
        hit_count_next      = hit_count_reg;
        miss_count_next     = sat_inc(miss_count_reg);
        miss_run_next       = sat_inc(miss_run_reg);
        window_size_next    = window_size_reg;
        window_cap_next     = window_cap_reg;
        run_state_next      = run_state_reg;
        hidden_en_next      = hidden_en_reg;
        hidden_skipped_next = hidden_skipped_reg;
        hidden_missed_next  = hidden_missed_reg;
        ram_wr_en           = 1'b0;
        ram_wr_addr         = next_pos_reg;
        ram_wr_data         = 1'b0;
        result              = '0;

        if (fire) begin
            case (in_item_reg.req_type)
                pwt_pkg::REQ_ISSUE: begin
                    if (run_state_reg != RS_RUNNING || in_item_reg.end_of_list) begin
                        run_state_next = RS_STOPPED;
                        result.status  = pwt_pkg::ST_PRODUCER_STOP;
                    end else if (in_item_reg.entry_hidden && !hidden_en_reg) begin
                        hidden_skipped_next = sat_inc(hidden_skipped_reg);
                        result.status       = pwt_pkg::ST_HIDDEN_SKIPPED;
                    end else if ({2'b00, next_slot_reg} >= issue_limit) begin
                        result.status = pwt_pkg::ST_WINDOW_FULL;
                    end else if (slot_count_reg >= CNT_W'(pwt_pkg::RING_DEPTH)) begin
                        result.status = pwt_pkg::ST_RING_FULL;
                    end else begin
                        // Append a slot; a failed send is done at once and stops.
                        if (slot_count_reg == '0) begin
                            head_slot_next = next_slot_reg;
                            head_pos_next  = next_pos_reg;
                        end
                        result.slot_index = next_slot_reg;
                        slot_count_next   = slot_count_reg + 1'b1;
                        next_slot_next    = next_slot_reg + 1'b1;
                        next_pos_next     = pos_inc(next_pos_reg, next_slot_reg);
                        ram_wr_en         = 1'b1;
                        ram_wr_addr       = next_pos_reg;
                        ram_wr_data       = !in_item_reg.issue_ok;
                        if (!in_item_reg.issue_ok) begin
                            run_state_next = RS_STOPPED;
                            result.status  = pwt_pkg::ST_PRODUCER_STOP;
                        end
                    end
                end
                pwt_pkg::REQ_REPLY: begin
                    if (reply_found) begin
                        ram_wr_en          = 1'b1;
                        ram_wr_addr        = reply_pos;
                        ram_wr_data        = 1'b1;
                        result.reply_place = (reply_off == '0) ? pwt_pkg::PLACE_HEAD
                                                               : pwt_pkg::PLACE_LATER;
                    end
                end
                pwt_pkg::REQ_CONSUME: begin
                    if (run_state_reg == RS_STOPPED && slot_count_reg == '0) begin
                        result.status = pwt_pkg::ST_DRAINED;
                    end else if (in_item_reg.entry_hidden && !hidden_en_reg
                                 && hidden_missed_reg < hidden_skipped_reg) begin
                        hidden_en_next     = 1'b1;
                        hidden_missed_next = sat_inc(hidden_missed_reg);
                        result.status      = pwt_pkg::ST_HIDDEN_MISSED;
                    end else if (slot_count_reg != '0 && head_done) begin
                        result.status = pwt_pkg::ST_OK;
                    end else if (run_state_reg == RS_STOPPED) begin
                        result.status = pwt_pkg::ST_OK;
                    end else begin
                        result.status = pwt_pkg::ST_NOT_READY;
                    end
                end
                pwt_pkg::REQ_ACCOUNT: begin
                    if (in_item_reg.was_hit) begin
                        hit_count_next   = sat_inc(hit_count_reg);
                        miss_run_next    = '0;
                        miss_count_next  = miss_count_reg;
                        window_size_next = (window_dbl < {1'b0, window_cap_reg})
                                         ? window_dbl[WIN_W-1:0] : window_cap_reg;
                    end else if (low_ratio && run_state_reg == RS_RUNNING) begin
                        run_state_next     = RS_STOPPING;
                        result.stop_raised = 1'b1;
                    end
                    // Pop the head slot.
                    if (slot_count_reg != '0) begin
                        head_slot_next  = head_slot_reg + 1'b1;
                        head_pos_next   = pos_inc(head_pos_reg, head_slot_reg);
                        slot_count_next = slot_count_reg - 1'b1;
                    end
                end
                pwt_pkg::REQ_STOP: begin
                    if (run_state_reg == RS_RUNNING) begin
                        run_state_next = RS_STOPPING;
                    end
                end
                default: begin
                end
            endcase
        end

        // Miss counters count only accounted misses; an accounted hit clears the miss run.
        if (!(fire && in_item_reg.req_type == pwt_pkg::REQ_ACCOUNT)) begin
            miss_count_next = miss_count_reg;
            miss_run_next   = miss_run_reg;
        end

        // Configuration writes load the live state directly.
        if (cfg_wr_en) begin
            case (cfg_wr_index)
                pwt_pkg::CFG_WINDOW_START:    window_size_next = cfg_wr_data;
                pwt_pkg::CFG_WINDOW_CAP:      window_cap_next  = cfg_wr_data;
                pwt_pkg::CFG_HIDDEN_ON_START: hidden_en_next   = cfg_wr_data[0];
                default: begin
                end
            endcase
        end
    end

    // A write to the slot that becomes the head is forwarded past the RAM.
    assign fwd_hit_next = ram_wr_en && (ram_wr_addr == head_pos_next);

    // Control and state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg       <= 1'b0;
            m_valid_reg        <= 1'b0;
            next_slot_reg      <= '0;
            head_slot_reg      <= '0;
            next_pos_reg       <= '0;
            head_pos_reg       <= '0;
            slot_count_reg     <= '0;
            hit_count_reg      <= '0;
            miss_count_reg     <= '0;
            miss_run_reg       <= '0;
            window_size_reg    <= WINDOW_START_RST;
            window_cap_reg     <= WINDOW_CAP_RST;
            run_state_reg      <= RS_RUNNING;
            hidden_en_reg      <= 1'b0;
            hidden_skipped_reg <= '0;
            hidden_missed_reg  <= '0;
            fwd_hit_reg        <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            next_slot_reg      <= next_slot_next;
            head_slot_reg      <= head_slot_next;
            next_pos_reg       <= next_pos_next;
            head_pos_reg       <= head_pos_next;
            slot_count_reg     <= slot_count_next;
            hit_count_reg      <= hit_count_next;
            miss_count_reg     <= miss_count_next;
            miss_run_reg       <= miss_run_next;
            window_size_reg    <= window_size_next;
            window_cap_reg     <= window_cap_next;
            run_state_reg      <= run_state_next;
            hidden_en_reg      <= hidden_en_next;
            hidden_skipped_reg <= hidden_skipped_next;
            hidden_missed_reg  <= hidden_missed_next;
            fwd_hit_reg        <= fwd_hit_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
        if (fire) begin
            m_item_reg <= result;
        end
        fwd_data_reg <= ram_wr_data;
    end

    // Done bits of the ring, read at the head of the coming cycle.
    pwt_ram #(
        .WIDTH (1),
        .DEPTH (pwt_pkg::RING_DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (head_pos_next),
        .rd_data (ram_rd_data)
    );

endmodule

[design/pwt_checker.sv]
// Port-level checks of the prefetch window tracker and their bind.
module pwt_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input pwt_pkg::out_item_t m_item
);

    // A stalled result item holds its value.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result item changed while stalled");

    // Reset leaves no result item pending.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result item valid after reset");

    // Only an issue that created a slot reports a slot index.
    a_slot_index_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.slot_index != '0 |->
            m_item.status == pwt_pkg::ST_OK
            || m_item.status == pwt_pkg::ST_PRODUCER_STOP)
        else $error("slot index with a status that creates no slot");

    // A raised stop comes only from an account, which reports nothing else.
    a_stop_raised_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.stop_raised |->
            m_item.status == pwt_pkg::ST_OK && m_item.slot_index == '0
            && m_item.reply_place == pwt_pkg::PLACE_NONE)
        else $error("stop raised together with other result fields");

    // A reply placement never carries an undefined code.
    a_reply_place_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_item.reply_place != 2'd3)
        else $error("undefined reply placement code");

endmodule

bind prefetch_window_tracker_unit pwt_checker u_pwt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
